>>> sv/pgga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgga_pkg: shared types and constants of the pixel to gray/alpha converter
// Pixel type codes, configuration register indexes, luma weights and the
// structures that travel between the converter's modules.
// ----------------------------------------------------------------------------
package pgga_pkg;

    localparam logic [7:0] LUMA_R       = 8'd77;
    localparam logic [7:0] LUMA_G       = 8'd150;
    localparam logic [7:0] LUMA_B       = 8'd29;
    localparam logic [7:0] FULL         = 8'd255;
    localparam logic [7:0] UNKNOWN_GRAY = 8'd128;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [1:0] CFG_PIXEL_TYPE        = 2'd0;
    localparam logic [1:0] CFG_PALETTE_PRESENT   = 2'd1;
    localparam logic [1:0] CFG_PALETTE_HAS_ALPHA = 2'd2;

    typedef enum logic [2:0] {
        PIX_GRAY        = 3'd0,
        PIX_TRUECOLOR   = 3'd1,
        PIX_INDEXED     = 3'd2,
        PIX_GRAY_ALPHA  = 3'd3,
        PIX_TRUE_ALPHA  = 3'd4
    } t_pix_type;

    typedef struct packed {
        t_pix_type pixel_type;
        logic      palette_present;
        logic      palette_has_alpha;
    } t_cfg;

    typedef struct packed {
        logic       we;
        logic [7:0] idx;
        logic [23:0] color;
        logic [7:0] alpha;
    } t_pal_wr;

    typedef struct packed {
        logic [7:0] comp0;
        logic [7:0] comp1;
        logic [7:0] comp2;
        logic [7:0] comp3;
        logic       end_of_row;
    } t_pix;

    function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [15:0] sum;
        sum = {8'd0, r} * {8'd0, LUMA_R} + {8'd0, g} * {8'd0, LUMA_G}
            + {8'd0, b} * {8'd0, LUMA_B};
        return sum[15:8];
    endfunction

endpackage
`default_nettype wire

>>> sv/pgga_palette.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgga_palette: palette color and alpha memories
// One write port and one read port with registered read data. The read
// register holds while the read enable is low.
// ----------------------------------------------------------------------------
module pgga_palette
    import pgga_pkg::*;
(
    input  wire logic    i_clk,
    input  wire t_pal_wr i_wr,
    input  wire logic    i_rd_en,
    input  wire logic [7:0] i_rd_idx,
    output logic [23:0]  o_color,
    output logic [7:0]   o_alpha
);

    logic [23:0] r_color_mem [256];
    logic [7:0]  r_alpha_mem [256];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_color_mem[i_wr.idx] <= i_wr.color;
            r_alpha_mem[i_wr.idx] <= i_wr.alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_color <= r_color_mem[i_rd_idx];
            o_alpha <= r_alpha_mem[i_rd_idx];
        end
    end

endmodule
`default_nettype wire

>>> sv/pgga_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgga_convert: gray and alpha pipeline
// Selects the gray source and alpha per pixel type, blends over white and
// divides by 255 in three registered stages that end in the output register.
// ----------------------------------------------------------------------------
module pgga_convert
    import pgga_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_pix        i_pix,
    input  wire logic [23:0] i_pal_color,
    input  wire logic [7:0]  i_pal_alpha,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic        r_s2_valid, r_s3_valid, r_s4_valid;
    logic        w_rdy2, w_rdy3, w_rdy4;
    logic [7:0]  r_s2_gray, r_s2_alpha;
    logic        r_s2_blend, r_s2_eor;
    logic [15:0] r_s3_x;
    logic [7:0]  r_s3_alpha;
    logic        r_s3_eor;
    logic [7:0]  r_s4_gray, r_s4_alpha;
    logic        r_s4_eor;
    logic [7:0]  n_gray, n_alpha, w_luma_pix, w_luma_pal, w_na;
    logic        n_blend;
    logic [15:0] n_x, w_q_sum;

    assign w_rdy4  = !r_s4_valid || m_axis_tready;
    assign w_rdy3  = !r_s3_valid || w_rdy4;
    assign w_rdy2  = !r_s2_valid || w_rdy3;
    assign o_ready = w_rdy2;

    assign w_luma_pix = luma(i_pix.comp0, i_pix.comp1, i_pix.comp2);
    assign w_luma_pal = luma(i_pal_color[23:16], i_pal_color[15:8], i_pal_color[7:0]);

    always_comb begin
        n_gray  = UNKNOWN_GRAY;
        n_alpha = FULL;
        n_blend = 1'b0;
        unique case (i_cfg.pixel_type)
            PIX_GRAY: begin
                n_gray = i_pix.comp0;
            end
            PIX_TRUECOLOR: begin
                n_gray = w_luma_pix;
            end
            PIX_INDEXED: begin
                if (i_cfg.palette_present) begin
                    n_gray = w_luma_pal;
                    if (i_cfg.palette_has_alpha) begin
                        n_alpha = i_pal_alpha;
                    end
                end else begin
                    n_gray = i_pix.comp0;
                end
            end
            PIX_GRAY_ALPHA: begin
                n_gray  = i_pix.comp0;
                n_alpha = i_pix.comp1;
                n_blend = 1'b1;
            end
            PIX_TRUE_ALPHA: begin
                n_gray  = w_luma_pix;
                n_alpha = i_pix.comp3;
                n_blend = 1'b1;
            end
            default: begin
                n_gray = UNKNOWN_GRAY;
            end
        endcase
    end

    // Without blending the value is gray times 255, which the divide returns as is.
    assign w_na = FULL - r_s2_alpha;
    assign n_x  = r_s2_blend
        ? ({8'd0, r_s2_gray} * {8'd0, r_s2_alpha} + (({8'd0, w_na} << 8) - {8'd0, w_na}))
        : (({8'd0, r_s2_gray} << 8) - {8'd0, r_s2_gray});

    // Exact floor division by 255 for any dividend up to 255 times 255.
    assign w_q_sum = r_s3_x + (r_s3_x >> 8) + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_rdy2) r_s2_valid <= i_valid;
            if (w_rdy3) r_s3_valid <= r_s2_valid;
            if (w_rdy4) r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_gray  <= n_gray;
            r_s2_alpha <= n_alpha;
            r_s2_blend <= n_blend;
            r_s2_eor   <= i_pix.end_of_row;
        end
        if (w_rdy3) begin
            r_s3_x     <= n_x;
            r_s3_alpha <= r_s2_alpha;
            r_s3_eor   <= r_s2_eor;
        end
        if (w_rdy4) begin
            r_s4_gray  <= w_q_sum[15:8];
            r_s4_alpha <= r_s3_alpha;
            r_s4_eor   <= r_s3_eor;
        end
    end

    assign m_axis_tvalid = r_s4_valid;
    assign m_axis_tdata  = {r_s4_alpha, r_s4_gray};
    assign m_axis_tlast  = r_s4_eor;

endmodule
`default_nettype wire

>>> sv/png_pixel_to_gray_alpha.sv
`default_nettype none
// ----------------------------------------------------------------------------
// png_pixel_to_gray_alpha: PNG pixel to 8-bit gray and alpha converter
// Configuration registers, palette memory and the input stage of the
// conversion pipeline.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while it is not stalled. The
// palette read register and the input stage are loaded at the acceptance edge
// of a conversion. Then come type selection and luma, the blend product and
// the divide by 255 into the output register. A stalled output holds the whole
// pipeline, and the input stalls only when all four stages are full. A palette
// write is stored at its acceptance edge and gives no result, so a pixel that
// follows in the next cycle already sees the new entry. Configuration may be
// written only while no pixel is in flight.
module png_pixel_to_gray_alpha
    import pgga_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [2:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // comp0, comp1, comp2, comp3, entry_index, entry_red, entry_green,
    // entry_blue, entry_alpha
    input  wire logic [71:0] s_axis_tdata,
    // op
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // gray, alpha
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    t_cfg        r_cfg;
    t_pal_wr     w_pal_wr;
    t_pix        r_s1_pix;
    logic        r_s1_valid;
    logic        w_cv_ready, w_accept;
    logic [23:0] w_pal_color;
    logic [7:0]  w_pal_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_type        <= PIX_GRAY;
            r_cfg.palette_present   <= 1'b0;
            r_cfg.palette_has_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            priority case (i_cfg_addr)
                CFG_PIXEL_TYPE:        r_cfg.pixel_type        <= t_pix_type'(i_cfg_data);
                CFG_PALETTE_PRESENT:   r_cfg.palette_present   <= i_cfg_data[0];
                CFG_PALETTE_HAS_ALPHA: r_cfg.palette_has_alpha <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !r_s1_valid || w_cv_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_pal_wr.we    = w_accept && (s_axis_tuser == OP_PALETTE);
    assign w_pal_wr.idx   = s_axis_tdata[39:32];
    assign w_pal_wr.color = {s_axis_tdata[47:40], s_axis_tdata[55:48], s_axis_tdata[63:56]};
    assign w_pal_wr.alpha = s_axis_tdata[71:64];

    pgga_palette u_palette (
        .i_clk    (i_clk),
        .i_wr     (w_pal_wr),
        .i_rd_en  (s_axis_tready),
        .i_rd_idx (s_axis_tdata[7:0]),
        .o_color  (w_pal_color),
        .o_alpha  (w_pal_alpha)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= w_accept && (s_axis_tuser == OP_CONVERT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_s1_pix.comp0      <= s_axis_tdata[7:0];
            r_s1_pix.comp1      <= s_axis_tdata[15:8];
            r_s1_pix.comp2      <= s_axis_tdata[23:16];
            r_s1_pix.comp3      <= s_axis_tdata[31:24];
            r_s1_pix.end_of_row <= s_axis_tlast;
        end
    end

    pgga_convert u_convert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (r_s1_valid),
        .o_ready       (w_cv_ready),
        .i_pix         (r_s1_pix),
        .i_pal_color   (w_pal_color),
        .i_pal_alpha   (w_pal_alpha),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> sv/pgga_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgga_checker: port checks for the pixel to gray/alpha converter
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module pgga_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The input side stalls only when the whole pipeline is full and blocked.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the output is free");

endmodule

bind png_pixel_to_gray_alpha pgga_checker u_pgga_checker (.*);
`default_nettype wire
